// File: design/d2r_pkg.sv
`default_nettype none
package d2r_pkg;

  localparam int VALUE_W  = 14;
  localparam int SYMBOL_W = 7;
  localparam int DIGIT_W  = 4;
  localparam int PLACES   = 4;

  // Multiply-by-reciprocal for divide by ten: exact for any 14-bit value.
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_10 = 16'd52429;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Digits by place: index 0 is thousands, index 3 is units.
  typedef logic [PLACES-1:0][DIGIT_W-1:0] digits_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_SPLIT,
    FR_PUSH
  } front_state_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  // Letter kinds inside one place.
  localparam logic [1:0] SH_END  = 2'd0;
  localparam logic [1:0] SH_ONE  = 2'd1;
  localparam logic [1:0] SH_FIVE = 2'd2;
  localparam logic [1:0] SH_TEN  = 2'd3;

  localparam logic [SYMBOL_W-1:0] CH_I = 7'h49;
  localparam logic [SYMBOL_W-1:0] CH_V = 7'h56;
  localparam logic [SYMBOL_W-1:0] CH_X = 7'h58;
  localparam logic [SYMBOL_W-1:0] CH_L = 7'h4C;
  localparam logic [SYMBOL_W-1:0] CH_C = 7'h43;
  localparam logic [SYMBOL_W-1:0] CH_D = 7'h44;
  localparam logic [SYMBOL_W-1:0] CH_M = 7'h4D;

  // Letter kind at position pos of the pattern for one decimal digit.
  function automatic logic [1:0] digit_shape(input logic [DIGIT_W-1:0] digit,
                                             input logic [1:0] pos);
    logic [1:0] s;
    s = SH_END;
    case (digit)
      4'd1: s = (pos == 2'd0) ? SH_ONE : SH_END;
      4'd2: s = (pos <= 2'd1) ? SH_ONE : SH_END;
      4'd3: s = (pos <= 2'd2) ? SH_ONE : SH_END;
      4'd4: s = (pos == 2'd0) ? SH_ONE : ((pos == 2'd1) ? SH_FIVE : SH_END);
      4'd5: s = (pos == 2'd0) ? SH_FIVE : SH_END;
      4'd6: s = (pos == 2'd0) ? SH_FIVE : ((pos == 2'd1) ? SH_ONE : SH_END);
      4'd7: s = (pos == 2'd0) ? SH_FIVE : ((pos <= 2'd2) ? SH_ONE : SH_END);
      4'd8: s = (pos == 2'd0) ? SH_FIVE : SH_ONE;
      4'd9: s = (pos == 2'd0) ? SH_ONE : ((pos == 2'd1) ? SH_TEN : SH_END);
      default: s = SH_END;
    endcase
    return s;
  endfunction

  function automatic logic [SYMBOL_W-1:0] place_letter(input logic [1:0] place,
                                                       input logic [1:0] shape);
    logic [SYMBOL_W-1:0] c;
    c = CH_M;
    case (place)
      2'd0: c = CH_M;
      2'd1: c = (shape == SH_ONE) ? CH_C : ((shape == SH_FIVE) ? CH_D : CH_M);
      2'd2: c = (shape == SH_ONE) ? CH_X : ((shape == SH_FIVE) ? CH_L : CH_C);
      2'd3: c = (shape == SH_ONE) ? CH_I : ((shape == SH_FIVE) ? CH_V : CH_X);
      default: c = CH_M;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: design/d2r_front.sv
`default_nettype none
module d2r_front
  import d2r_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [VALUE_W-1:0] value,
  output logic                    push,
  output digits_t                 push_digits,
  input  wire logic               push_ready
);

  front_state_t state, state_next;
  logic [VALUE_W-1:0] quot;
  logic [1:0]         cnt;
  digits_t            digits;

  logic [VALUE_W+RECIP_W-1:0] prod;
  logic [VALUE_W-1:0]         quot_next;
  logic [VALUE_W-1:0]         diff;
  logic [DIGIT_W-1:0]         rem;
  logic                       all_zero;

  // One divide-by-ten step per cycle: quotient by reciprocal, remainder by subtraction.
  assign prod      = quot * {{VALUE_W{1'b0}}, RECIP_10};
  assign quot_next = VALUE_W'(prod >> RECIP_SHIFT);
  assign diff      = quot - ((quot_next << 3) + (quot_next << 1));
  assign rem       = diff[DIGIT_W-1:0];

  always_comb begin
    digits_t d;
    d = digits;
    // A thousands digit above three emits nothing.
    if (d[0] > 4'd3) begin
      d[0] = '0;
    end
    push_digits = d;
    all_zero    = (d == '0);
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    push       = 1'b0;
    case (state)
      FR_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = FR_SPLIT;
        end
      end
      FR_SPLIT: begin
        if (cnt == 2'd3) begin
          state_next = FR_PUSH;
        end
      end
      FR_PUSH: begin
        // Zero produces no characters and is dropped here.
        if (all_zero) begin
          state_next = FR_IDLE;
        end else if (push_ready) begin
          push       = 1'b1;
          state_next = FR_IDLE;
        end
      end
      default: state_next = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == FR_IDLE) begin
        cnt <= '0;
      end else if (state == FR_SPLIT) begin
        cnt <= cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == FR_IDLE && in_valid) begin
      quot <= value;
    end else if (state == FR_SPLIT) begin
      quot        <= quot_next;
      digits[~cnt] <= rem;
    end
  end

endmodule
`default_nettype wire

// File: design/d2r_queue.sv
`default_nettype none
module d2r_queue
  import d2r_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    wr,
  input  wire digits_t wr_data,
  output logic         wr_ready,
  input  wire logic    rd,
  output digits_t      rd_data,
  output logic         rd_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  digits_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr && wr_ready) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd && rd_valid) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({wr && wr_ready, rd && rd_valid})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr && wr_ready) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// File: design/d2r_back.sv
`default_nettype none
module d2r_back
  import d2r_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  wire digits_t             q_data,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [SYMBOL_W-1:0]      symbol,
  output logic                     last
);

  back_state_t state, state_next;
  digits_t     digits;
  logic [1:0]  place, place_next;
  logic [1:0]  pos, pos_next;
  logic        out_valid_next;
  logic [SYMBOL_W-1:0] symbol_next;
  logic        last_next;

  logic        adv;
  logic [1:0]  shape, shape_after;
  logic        tail_zero;

  assign adv         = !out_valid || out_ready;
  assign shape       = digit_shape(digits[place], pos);
  assign shape_after = (pos == 2'd3) ? SH_END : digit_shape(digits[place], pos + 2'd1);

  always_comb begin
    tail_zero = 1'b1;
    for (int k = 0; k < PLACES; k++) begin
      if (k > int'(place) && digits[k] != '0) begin
        tail_zero = 1'b0;
      end
    end
  end

  always_comb begin
    state_next     = state;
    place_next     = place;
    pos_next       = pos;
    pop            = 1'b0;
    out_valid_next = out_valid && !out_ready;
    symbol_next    = symbol;
    last_next      = last;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          place_next = '0;
          pos_next   = '0;
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        if (adv) begin
          if (shape != SH_END) begin
            out_valid_next = 1'b1;
            symbol_next    = place_letter(place, shape);
            last_next      = (shape_after == SH_END) && tail_zero;
          end
          if (shape == SH_END || shape_after == SH_END) begin
            pos_next   = '0;
            place_next = place + 2'd1;
            if (place == 2'd3) begin
              state_next = BK_IDLE;
            end
          end else begin
            pos_next = pos + 2'd1;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
      place     <= '0;
      pos       <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      place     <= place_next;
      pos       <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    symbol <= symbol_next;
    last   <= last_next;
    if (pop) begin
      digits <= q_data;
    end
  end

endmodule
`default_nettype wire

// File: design/decimal_to_roman_numeral.sv
`default_nettype none
// Decimal to Roman numeral converter.
// The input channel (in_valid, in_ready, value) takes one number per item.
// The output channel (out_valid, out_ready, symbol, last) returns the numeral
// as one ASCII letter per item, most significant place first, with last set
// on the final letter. A number whose numeral is empty returns nothing: one
// whose low four decimal digits are all zero, or whose only nonzero one of
// them is a thousands digit above three. The front splits the number into
// four decimal digits, one divide-by-ten step per cycle through a reciprocal
// multiplier, and takes no new number until it is through with the last one.
// A two-entry queue of digit sets separates it from the back, which, unless
// the receiver stalls, emits one letter per cycle; it also passes over each
// place whose digit is zero and loads the next digit set in steps that emit
// no letter. A numeral has at most fifteen letters.
// Before the first letter of an item appears, the front splits its digits
// and pushes them into the queue, the back pops them, and the back passes
// over each leading place whose digit is zero.
// Reset empties the queue, drops work in flight and clears out_valid.
// When the receiver stalls, the letter in the output register holds, the
// back waits, and the front keeps splitting until the queue is full.
module decimal_to_roman_numeral
  import d2r_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [VALUE_W-1:0]  value,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [SYMBOL_W-1:0]      symbol,
  output logic                     last
);

  logic    push, push_ready;
  digits_t push_digits;
  logic    pop, q_valid;
  digits_t q_data;

  // Front: accepts numbers and splits them into digits.
  d2r_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .value       (value),
    .push        (push),
    .push_digits (push_digits),
    .push_ready  (push_ready)
  );

  // Queue of digit sets between the two halves.
  d2r_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (push),
    .wr_data  (push_digits),
    .wr_ready (push_ready),
    .rd       (pop),
    .rd_data  (q_data),
    .rd_valid (q_valid)
  );

  // Back: walks places and letter patterns, one letter per cycle while not stalled.
  d2r_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .symbol    (symbol),
    .last      (last)
  );

endmodule
`default_nettype wire

// File: design/d2r_checker.sv
`default_nettype none
module d2r_checker
  import d2r_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [SYMBOL_W-1:0] symbol,
  input wire logic                last
);

  // A stalled letter holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(symbol) && $stable(last))
    else $error("output item changed while stalled");

  // Only numeral letters are ever shown.
  a_letter: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (symbol == CH_I || symbol == CH_V || symbol == CH_X ||
                   symbol == CH_L || symbol == CH_C || symbol == CH_D ||
                   symbol == CH_M))
    else $error("symbol is not a numeral letter");

  // The front is busy splitting right after it takes a number.
  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted during digit split");

  // Reset leaves nothing on the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind decimal_to_roman_numeral d2r_checker u_d2r_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .symbol    (symbol),
  .last      (last)
);
`default_nettype wire
